/* rtl/wahrb_pkg.sv */
// Shared types and constants for the wah resonator biquad.
`default_nettype none

package wahrb_pkg;

    // Register indexes on the APB port (paddr[2])
    localparam logic REG_POLE_RADIUS = 1'b0;
    localparam logic REG_COS_CENTER  = 1'b1;

    localparam logic [15:0]        POLE_RADIUS_RESET = 16'd64881;
    localparam logic signed [15:0] COS_CENTER_RESET  = 16'sd32000;

    // Unity in the Q.16 coefficient format
    localparam logic signed [17:0] COEF_ONE = 18'sd65536;

    // Terms are floored to F+8 fraction bits, then rounded half up to F bits
    localparam int PROD_SHIFT = 8;
    localparam int A1_SHIFT   = 22;
    localparam int ROUND_BITS = 8;
    localparam int ROUND_HALF = 128;

    typedef struct packed {
        logic [15:0]        pole_radius;
        logic signed [15:0] cos_center;
        logic signed [17:0] b0;   // 1 - g, Q.16
        logic signed [31:0] a1;   // 2*g*cos, Q.30
        logic signed [17:0] a2;   // 1 - 2g, Q.16
    } coef_t;

endpackage

`default_nettype wire

/* rtl/wahrb_cfg.sv */
// APB register file holding g and cos(theta), with the derived filter coefficients.
`default_nettype none

module wahrb_cfg (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [2:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output wahrb_pkg::coef_t   coef
);
    import wahrb_pkg::*;

    logic [15:0]        pole_radius_reg;
    logic [15:0]        pole_radius_next;
    logic signed [15:0] cos_center_reg;
    logic signed [15:0] cos_center_next;
    logic signed [17:0] b0_reg;
    logic signed [17:0] b0_next;
    logic signed [31:0] a1_reg;
    logic signed [31:0] a1_next;
    logic signed [17:0] a2_reg;
    logic signed [17:0] a2_next;
    logic signed [32:0] gc_prod;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb begin
        pole_radius_next = pole_radius_reg;
        cos_center_next  = cos_center_reg;
        if (!aresetn) begin
            pole_radius_next = POLE_RADIUS_RESET;
            cos_center_next  = COS_CENTER_RESET;
        end else if (wr_en) begin
            case (paddr[2])
                REG_POLE_RADIUS: pole_radius_next = pwdata[15:0];
                REG_COS_CENTER:  cos_center_next  = $signed(pwdata[15:0]);
                default: ;
            endcase
        end
    end

    // Coefficients are derived from the next register values, so they update together with the registers
    always_comb begin
        gc_prod = $signed({1'b0, pole_radius_next}) * cos_center_next;
        a1_next = gc_prod[31:0];
        b0_next = COEF_ONE - $signed({2'b00, pole_radius_next});
        a2_next = COEF_ONE - $signed({1'b0, pole_radius_next, 1'b0});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pole_radius_reg <= POLE_RADIUS_RESET;
            cos_center_reg  <= COS_CENTER_RESET;
        end else begin
            pole_radius_reg <= pole_radius_next;
            cos_center_reg  <= cos_center_next;
        end
    end

    always_ff @(posedge aclk) begin
        b0_reg <= b0_next;
        a1_reg <= a1_next;
        a2_reg <= a2_next;
    end

    always_comb begin
        case (paddr[2])
            REG_POLE_RADIUS: prdata = {16'd0, pole_radius_reg};
            REG_COS_CENTER:  prdata = 32'(cos_center_reg);
            default:         prdata = 32'd0;
        endcase
    end

    assign coef.pole_radius = pole_radius_reg;
    assign coef.cos_center  = cos_center_reg;
    assign coef.b0          = b0_reg;
    assign coef.a1          = a1_reg;
    assign coef.a2          = a2_reg;

endmodule

`default_nettype wire

/* rtl/wahrb_filter.sv */
// Resonator datapath: delay line state, feedback recursion and output saturation.
`default_nettype none

module wahrb_filter #(
    parameter int SAMPLE_BITS   = 24,
    parameter int FEEDBACK_BITS = 32
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          step,
    input  wire logic signed [SAMPLE_BITS-1:0] x,
    input  wire wahrb_pkg::coef_t              coef,
    output logic [SAMPLE_BITS-1:0]             wah_sample
);
    import wahrb_pkg::*;

    localparam int MAX_W = (SAMPLE_BITS > FEEDBACK_BITS) ? SAMPLE_BITS : FEEDBACK_BITS;
    localparam int ACC_W = MAX_W + 13;

    localparam logic signed [ACC_W-1:0] FB_HI =
        {{(ACC_W-FEEDBACK_BITS+1){1'b0}}, {(FEEDBACK_BITS-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] FB_LO = ~FB_HI;
    localparam logic signed [ACC_W-1:0] OUT_HI =
        {{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] OUT_LO = ~OUT_HI;

    logic signed [SAMPLE_BITS-1:0]     xd1_reg;
    logic signed [SAMPLE_BITS-1:0]     xd2_reg;
    logic signed [FEEDBACK_BITS-1:0]   yd1_reg;
    logic signed [FEEDBACK_BITS-1:0]   yd2_reg;
    logic [SAMPLE_BITS-1:0]            wah_sample_reg;

    logic signed [SAMPLE_BITS:0]       diff;
    logic signed [SAMPLE_BITS+18:0]    p1;
    logic signed [FEEDBACK_BITS+31:0]  p2;
    logic signed [FEEDBACK_BITS+17:0]  p3;
    logic signed [ACC_W-1:0]           acc;
    logic signed [ACC_W-1:0]           y_wide;
    logic signed [ACC_W-1:0]           y_fb;
    logic signed [ACC_W-1:0]           y_out;
    logic [SAMPLE_BITS-1:0]            wah_sample_next;

    always_comb begin
        diff = {x[SAMPLE_BITS-1], x} - {xd2_reg[SAMPLE_BITS-1], xd2_reg};
        p1   = diff * coef.b0;
        p2   = yd1_reg * coef.a1;
        p3   = yd2_reg * coef.a2;
        // shifted terms fit well inside ACC_W, so the casts only drop sign copies
        acc  = ACC_W'(p1 >>> PROD_SHIFT) + ACC_W'(p2 >>> A1_SHIFT)
             + ACC_W'(p3 >>> PROD_SHIFT) + ACC_W'(ROUND_HALF);
        y_wide = acc >>> ROUND_BITS;

        if (y_wide > FB_HI) begin
            y_fb = FB_HI;
        end else if (y_wide < FB_LO) begin
            y_fb = FB_LO;
        end else begin
            y_fb = y_wide;
        end

        if (y_fb > OUT_HI) begin
            y_out = OUT_HI;
        end else if (y_fb < OUT_LO) begin
            y_out = OUT_LO;
        end else begin
            y_out = y_fb;
        end
        wah_sample_next = y_out[SAMPLE_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            xd1_reg <= '0;
            xd2_reg <= '0;
            yd1_reg <= '0;
            yd2_reg <= '0;
        end else if (step) begin
            xd2_reg <= xd1_reg;
            xd1_reg <= x;
            yd2_reg <= yd1_reg;
            yd1_reg <= y_fb[FEEDBACK_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            wah_sample_reg <= wah_sample_next;
        end
    end

    assign wah_sample = wah_sample_reg;

endmodule

`default_nettype wire

/* rtl/wah_resonator_biquad.sv */
// Top level of the wah resonator biquad: stream handshake, mono mix and register port.
//
//  channel | direction | payload
//  --------+-----------+---------------------------------------------------
//  s_axis  | in        | tdata: left_sample, right_sample (stereo pair)
//  m_axis  | out       | tdata: wah_sample (mono result, for both channels)
//  apb     | in/out    | 0x0 pole_radius (g, Q0.16), 0x4 cos_center (Q1.15)
//
// One item per cycle unless m_axis stalls; items pass x_reg, then the output register.
// Throughput is set by the feedback loop (y[n-1] into the next sum).
// Stage one registers the mono average, stage two runs the resonator into the
// output register. Both stages freeze while m_axis is stalled with a result held;
// a free stage one still takes a transfer. Reset is synchronous and restores the
// register defaults and clears the delay line.
`default_nettype none

module wah_resonator_biquad #(
    parameter int SAMPLE_BITS   = 24,
    parameter int FEEDBACK_BITS = 32
) (
    input  wire logic                                     aclk,
    input  wire logic                                     aresetn,

    input  wire logic                                     s_axis_tvalid,
    output logic                                          s_axis_tready,
    // [SAMPLE_BITS-1:0] left_sample, [2*SAMPLE_BITS-1:SAMPLE_BITS] right_sample
    input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0]       s_axis_tdata,

    output logic                                          m_axis_tvalid,
    input  wire logic                                     m_axis_tready,
    // [SAMPLE_BITS-1:0] wah_sample, zero fill above
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]              m_axis_tdata,

    input  wire logic                                     psel,
    input  wire logic                                     penable,
    input  wire logic                                     pwrite,
    input  wire logic [2:0]                               paddr,
    input  wire logic [31:0]                              pwdata,
    output logic [31:0]                                   prdata,
    output logic                                          pready
);
    import wahrb_pkg::*;

    localparam int M_TDATA_W = ((SAMPLE_BITS+7)/8)*8;

    coef_t                          coef;
    logic                           x_valid_reg;
    logic signed [SAMPLE_BITS-1:0]  x_reg;
    logic signed [SAMPLE_BITS:0]    lr_sum;
    logic                           m_valid_reg;
    logic                           pipe_en;
    logic                           load_x;
    logic                           step;
    logic [SAMPLE_BITS-1:0]         wah_sample;

    wahrb_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coef    (coef)
    );

    // Output register free or draining this cycle
    assign pipe_en = !m_valid_reg || m_axis_tready;
    assign load_x  = !x_valid_reg || pipe_en;
    assign step    = pipe_en && x_valid_reg;

    assign s_axis_tready = load_x;

    // floor((left + right) / 2)
    assign lr_sum = $signed({s_axis_tdata[SAMPLE_BITS-1], s_axis_tdata[SAMPLE_BITS-1:0]})
                  + $signed({s_axis_tdata[2*SAMPLE_BITS-1],
                             s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (load_x) begin
                x_valid_reg <= s_axis_tvalid;
            end
            if (pipe_en) begin
                m_valid_reg <= x_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_x && s_axis_tvalid) begin
            x_reg <= lr_sum[SAMPLE_BITS:1];
        end
    end

    wahrb_filter #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FEEDBACK_BITS (FEEDBACK_BITS)
    ) u_filter (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .x          (x_reg),
        .coef       (coef),
        .wah_sample (wah_sample)
    );

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = M_TDATA_W'(wah_sample);

    // A full mix stage always reaches the output once the output side moves
    ap_step_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> m_axis_tvalid)
        else $error("mixed sample did not reach the output register");

    // Input is refused only when both stages hold data and the output is stalled
    ap_ready_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> (x_valid_reg && m_valid_reg && !m_axis_tready))
        else $error("input refused with room in the pipeline");

    // Derived feedback coefficient tracks the register pair
    ap_a1_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (coef.a1 == ($signed({16'd0, coef.pole_radius})
                                        * 32'(coef.cos_center))))
        else $error("a1 coefficient out of step with g and cos_center");

endmodule

`default_nettype wire

/* tb/tb_wah_resonator_biquad.sv */
// Self-checking testbench for the wah resonator biquad: stream traffic, APB coefficients.
`timescale 1ns / 1ps

module tb_wah_resonator_biquad;
    import wahrb_pkg::*;

    localparam longint FB_MAX     = 64'sd2147483647;
    localparam longint FB_MIN     = -FB_MAX - 1;
    localparam longint WAH_MAX    = 64'sd8388607;
    localparam longint WAH_MIN    = -WAH_MAX - 1;
    localparam int     CYCLE_LIMIT = 200000;
    localparam int     PHASE_ITEMS = 95;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // coefficient shadow and filter state of the predictor
    logic [15:0]        pole_radius_q;
    logic signed [15:0] cos_center_q;
    longint             mono_d1, mono_d2;
    longint             wah_fb_d1, wah_fb_d2;

    logic [23:0] wah_expected[$];
    logic [23:0] wah_want;
    int          mismatch_count;
    int          cycle_count;
    bit          sender_steady;
    bit          receiver_steady;

    wah_resonator_biquad dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // One resonator step: mono mix, three floored terms, round half up, saturate.
    function automatic logic [23:0] resonate(input logic signed [23:0] left,
                                             input logic signed [23:0] right);
        longint g;
        longint c;
        longint mono;
        longint b0;
        longint a1;
        longint a2;
        longint acc;
        longint y;
        longint wah;
        g    = pole_radius_q;
        c    = cos_center_q;
        mono = (longint'(left) + longint'(right)) >>> 1;
        b0   = 65536 - g;
        a2   = 65536 - 2 * g;
        a1   = g * c;
        acc  = (b0 * (mono - mono_d2)) >>> 8;
        acc  = acc + ((wah_fb_d1 * a1) >>> 22);
        acc  = acc + ((wah_fb_d2 * a2) >>> 8);
        y    = (acc + 128) >>> 8;
        if (y > FB_MAX)
            y = FB_MAX;
        else if (y < FB_MIN)
            y = FB_MIN;
        wah = y;
        if (wah > WAH_MAX)
            wah = WAH_MAX;
        else if (wah < WAH_MIN)
            wah = WAH_MIN;
        mono_d2   = mono_d1;
        mono_d1   = mono;
        wah_fb_d2 = wah_fb_d1;
        wah_fb_d1 = y;
        return wah[23:0];
    endfunction

    function automatic logic signed [23:0] rand_sample();
        int unsigned pick;
        logic [31:0] r;
        pick = $urandom_range(0, 9);
        r    = $urandom;
        if (pick < 5)
            return r[23:0];
        if (pick < 8)
            return {{11{r[12]}}, r[12:0]};
        case (r[1:0])
            2'd0:    return 24'h7FFFFF;
            2'd1:    return 24'h800000;
            2'd2:    return 24'h000000;
            default: return 24'hFFFFFF;
        endcase
    endfunction

    task automatic send_pair(input logic signed [23:0] left, input logic signed [23:0] right);
        int gap;
        gap = sender_steady ? 0 : $urandom_range(0, 17);
        @(negedge aclk);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tdata  <= {right, left};
        s_axis_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        wah_expected.push_back(resonate(left, right));
    endtask

    task automatic wait_for_results();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (wah_expected.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apb_write(input logic addr_sel, input logic [15:0] value);
        logic [31:0] r;
        r = $urandom;
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {addr_sel, 2'b00};
        pwdata  <= {r[31:16], value};   // upper bits are don't-care
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_coefs(input logic [15:0] g, input logic signed [15:0] c);
        wait_for_results();
        apb_write(REG_POLE_RADIUS, g);
        pole_radius_q = g;
        apb_write(REG_COS_CENTER, c);
        cos_center_q = c;
    endtask

    // Reset coefficients; floor of odd sums and full-scale channel pairs.
    task automatic test_mono_average();
        send_pair(24'sh7FFFFF, 24'sh7FFFFF);
        send_pair(24'sh800000, 24'sh800000);
        send_pair(24'sh7FFFFF, 24'sh800000);
        send_pair(24'sh000001, 24'sh000000);
        send_pair(24'shFFFFFF, 24'sh000000);
        send_pair(24'sh000000, 24'shFFFFFE);
        send_pair(24'sh800000, 24'sh7FFFFE);
        send_pair(24'sh000000, 24'sh000000);
    endtask

    // Corner coefficient sets driven hard, so the output saturation stage sees traffic.
    task automatic test_coef_extremes();
        logic [15:0]        g_set[4] = '{16'd0, 16'd65535, 16'd32768, 16'd1};
        logic signed [15:0] c_set[4] = '{16'sh7FFF, -16'sd32768, -16'sd32768, 16'sh7FFF};
        for (int k = 0; k < 4; k++) begin
            write_coefs(g_set[k], c_set[k]);
            send_pair(24'sh7FFFFF, 24'sh7FFFFF);
            send_pair(24'sh7FFFFF, 24'sh7FFFFF);
            send_pair(24'sh800000, 24'sh800000);
            send_pair(24'sh800000, 24'sh800000);
        end
    endtask

    task automatic test_random_phases();
        logic [15:0]        g;
        logic signed [15:0] c;
        for (int p = 0; p < 9; p++) begin
            case (p)
                0: begin g = POLE_RADIUS_RESET; c = COS_CENTER_RESET; end
                1: begin g = 16'd0;             c = -16'sd32768;      end
                2: begin g = 16'd65535;         c = 16'sh7FFF;        end
                3: begin g = 16'd65535;         c = 16'sd0;           end
                4: begin g = 16'd1;             c = 16'sh7FFF;        end
                default: begin g = 16'($urandom); c = 16'($urandom); end
            endcase
            write_coefs(g, c);
            sender_steady   = (p % 3 == 2);
            receiver_steady = (p % 3 == 2) || (p == 7);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_pair(rand_sample(), rand_sample());
        end
        sender_steady   = 1'b0;
        receiver_steady = 1'b0;
    endtask

    // Sender holds off mid-stream until the pipeline has fully drained.
    task automatic test_drain_pause();
        for (int n = 0; n < 45; n++) begin
            send_pair(rand_sample(), rand_sample());
            if (n % 9 == 8)
                wait_for_results();
        end
    endtask

    // Receiver: random stall before each result, none in steady stretches.
    initial begin
        int stall;
        m_axis_tready = 1'b0;
        forever begin
            stall = receiver_steady ? 0 : $urandom_range(0, 17);
            @(negedge aclk);
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!m_axis_tvalid);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (wah_expected.size() == 0) begin
                $display("%0t: wah_sample with no transfer pending: expected none, got %0d",
                         $time, $signed(m_axis_tdata));
                mismatch_count++;
            end else begin
                wah_want = wah_expected.pop_front();
                if (m_axis_tdata !== wah_want) begin
                    $display("%0t: wah_sample mismatch: expected %0d, got %0d",
                             $time, $signed(wah_want), $signed(m_axis_tdata));
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, wah_expected.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        aresetn         = 1'b0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        mismatch_count  = 0;
        cycle_count     = 0;
        sender_steady   = 1'b0;
        receiver_steady = 1'b0;
        pole_radius_q   = POLE_RADIUS_RESET;
        cos_center_q    = COS_CENTER_RESET;
        mono_d1         = 0;
        mono_d2         = 0;
        wah_fb_d1       = 0;
        wah_fb_d2       = 0;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        test_mono_average();
        test_coef_extremes();
        test_random_phases();
        test_drain_pause();

        wait_for_results();
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
